// ----- hdl/swm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WINDOW_DEF = 5;
  localparam int DATA_W     = 16;

  // One slot of the sorted chain. A slot that is not valid counts as larger
  // than any sample.
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              vld;
  } swm_slot_t;

  // Per-item control broadcast to every cell of the chain.
  typedef struct packed {
    logic              step;
    logic              del_en;
    logic [DATA_W-1:0] new_val;
    logic [DATA_W-1:0] old_val;
  } swm_ctrl_t;

endpackage

// ----- hdl/sliding_window_median.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over the last WINDOW unsigned 16-bit samples.
// ----------------------------------------------------------------------------
// Latency: the result of an item is presented on the cycle after it is accepted.
// Throughput: one item per cycle while the output is not stalled; the whole
// remove-and-insert ripple through the row of WINDOW cells is combinational, and that ripple sets the rate.
// Reset: rst clears the fill count and the output valid; sample storage is not
// cleared, since no slot is read before a full window has been written again.
// ----------------------------------------------------------------------------
module sliding_window_median #(
  parameter int WINDOW = swm_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] median_value
  output logic        m_axis_tuser    // [0] median_valid
);

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [FILL_W-1:0] FULL = FILL_W'(WINDOW);

  logic                       accept;
  logic [FILL_W-1:0]          fill;
  logic [FILL_W-1:0]          fill_next;
  logic                       full_next;
  logic [swm_pkg::DATA_W-1:0] line [WINDOW];
  logic [swm_pkg::DATA_W-1:0] median_next;
  swm_pkg::swm_ctrl_t         ctrl;

  // The output register parts the two sides, so a new item can be taken in
  // the same cycle as the previous result leaves.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The fill count saturates at WINDOW. A restart empties the window; the
  // sample carried with a restart item is dropped.
  always_comb begin
    if (s_axis_tuser) begin
      fill_next = '0;
    end else if (fill == FULL) begin
      fill_next = fill;
    end else begin
      fill_next = fill + 1'b1;
    end
    full_next = (fill_next == FULL);
  end

  // The delay line holds samples in arrival order, so once the window is full
  // its last tap is the sample that leaves the window with this item.
  always_ff @(posedge clk) begin
    if (accept && !s_axis_tuser) begin
      line[0] <= s_axis_tdata;
      for (int k = 1; k < WINDOW; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  // While filling, nothing is removed: the new sample is inserted among the
  // valid slots and pushes an empty slot off the top of the chain.
  always_comb begin
    ctrl.step    = accept && !s_axis_tuser;
    ctrl.del_en  = (fill == FULL);
    ctrl.new_val = s_axis_tdata;
    ctrl.old_val = line[WINDOW-1];
  end

  swm_chain #(
    .WINDOW (WINDOW),
    .FILL_W (FILL_W)
  ) u_chain (
    .clk         (clk),
    .ctrl        (ctrl),
    .fill        (fill),
    .median_next (median_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        fill          <= fill_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= full_next ? median_next : '0;
      m_axis_tuser <= full_next;
    end
  end

`ifndef SYNTHESIS
  // The fill count never passes the window length.
  assert property (@(posedge clk) disable iff (rst) fill <= FULL)
    else $error("fill count beyond window");

  // A result that is not flagged valid carries a zero median.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("invalid result with nonzero median");

  // A restart item empties the window and yields an unflagged result.
  assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tuser) |=> (fill == '0 && m_axis_tvalid && !m_axis_tuser))
    else $error("restart did not empty the window");

  // The result flag follows the fill count.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (m_axis_tuser == (fill == FULL)))
    else $error("result flag disagrees with fill count");
`endif

endmodule

// ----- hdl/swm_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: removes the outgoing value and inserts the
// incoming one using only its own value and those of its two neighbors.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter bit IS_LAST = 1'b0
) (
  input  logic                      clk,
  input  swm_pkg::swm_ctrl_t        ctrl,
  input  logic                      vld,
  input  swm_pkg::swm_slot_t        right,
  input  logic                      found_in,
  output logic                      found_out,
  input  swm_pkg::swm_slot_t        r_left,
  input  logic                      gt_left,
  output swm_pkg::swm_slot_t        r_out,
  output logic                      gt_out,
  output logic [swm_pkg::DATA_W-1:0] val,
  output logic [swm_pkg::DATA_W-1:0] val_next
);

  logic               match;
  logic               shift;
  swm_pkg::swm_slot_t own;
  swm_pkg::swm_slot_t r;

  always_comb begin
    own.val   = val;
    own.vld   = vld;
    match     = ctrl.del_en && vld && (val == ctrl.old_val);
    shift     = found_in || match;
    found_out = shift;
    // The chain after removal: slots at or above the removed one take the
    // right neighbor. The last slot is always empty after removal.
    if (IS_LAST) begin
      r = '0;
    end else if (shift) begin
      r = right;
    end else begin
      r = own;
    end
    gt_out = !r.vld || (r.val > ctrl.new_val);
    r_out  = r;
    if (!gt_out) begin
      val_next = r.val;
    end else if (gt_left) begin
      val_next = r_left.val;
    end else begin
      val_next = ctrl.new_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      val <= val_next;
    end
  end

endmodule

// ----- hdl/swm_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_chain
// Row of sorted cells; slots below the fill count are valid.
// ----------------------------------------------------------------------------
module swm_chain #(
  parameter int WINDOW = swm_pkg::WINDOW_DEF,
  parameter int FILL_W = $clog2(WINDOW + 1)
) (
  input  logic                       clk,
  input  swm_pkg::swm_ctrl_t         ctrl,
  input  logic [FILL_W-1:0]          fill,
  output logic [swm_pkg::DATA_W-1:0] median_next
);

  logic [swm_pkg::DATA_W-1:0] val      [WINDOW];
  logic [swm_pkg::DATA_W-1:0] val_next [WINDOW];
  logic                       vld      [WINDOW];
  logic                       found    [WINDOW+1];
  logic                       gt       [WINDOW+1];
  swm_pkg::swm_slot_t         r        [WINDOW+1];
  swm_pkg::swm_slot_t         right    [WINDOW];

  assign found[0] = 1'b0;
  assign gt[0]    = 1'b0;
  assign r[0]     = '0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    assign vld[i] = (fill > FILL_W'(i));
    if (i == WINDOW - 1) begin : g_edge
      assign right[i] = '0;
    end else begin : g_mid
      assign right[i] = '{val: val[i+1], vld: vld[i+1]};
    end

    swm_cell #(
      .IS_LAST (i == WINDOW - 1)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .vld       (vld[i]),
      .right     (right[i]),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .r_left    (r[i]),
      .gt_left   (gt[i]),
      .r_out     (r[i+1]),
      .gt_out    (gt[i+1]),
      .val       (val[i]),
      .val_next  (val_next[i])
    );
  end

  assign median_next = val_next[WINDOW/2];

endmodule

// ----- tb/sliding_window_median_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_test
// Self-checking bench for the running median filter. A short directed run
// covers extreme samples, duplicates, restarts at several fill levels and
// fill saturation. A long random run follows, made mostly of whole windows
// with styled content and some short, broken runs. Both stream sides idle at
// random. Every result is checked against a software window that is sorted
// afresh for each item.
// ----------------------------------------------------------------------------
module sliding_window_median_test;

  localparam int DATA_W      = swm_pkg::DATA_W;
  localparam int WIN         = swm_pkg::WINDOW_DEF;
  localparam int LONG_HOLD   = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 300000;

  // Flag carried in tuser on the input side.
  localparam logic FEED    = 1'b0;
  localparam logic RESTART = 1'b1;

  // Shapes of sample content used by the random runs.
  typedef enum int {ANY_VALUE, NEAR_BASE, RAIL, ONE_HOT} value_style_e;

  typedef struct packed {
    logic [DATA_W-1:0] sample;
    logic              restart;
  } feed_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              full;
  } median_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  // Items still to be offered, and medians still to be received.
  feed_item_t samples_to_send[$];
  median_t    medians_due[$];

  // Copy of the filter window used to work out the expected medians.
  logic [DATA_W-1:0] ring_q [WIN];
  int                ring_ptr;
  int                ring_fill;

  // Handshakes seen at the last rising edge, read by the falling-edge drivers.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   feed_gap       = 0;
  logic feed_burst     = 1'b0;
  int   sink_wait      = 0;
  logic sink_burst     = 1'b0;
  int   holds_asked    = 0;
  int   holds_served   = 0;
  feed_item_t next_item;
  median_t    due;

  sliding_window_median uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] sample
    .s_axis_tuser  (s_axis_tuser),   // [0] restart
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] median_value
    .m_axis_tuser  (m_axis_tuser)    // [0] median_valid
  );

  always #5 clk = ~clk;

  // Applies one accepted item to the window copy and returns the median the
  // filter must report for it. The window is sorted from scratch each time,
  // so the result never depends on how the block keeps its sorted chain.
  function automatic median_t next_median(input feed_item_t item);
    logic [DATA_W-1:0] ordered [WIN];
    logic [DATA_W-1:0] key;
    int                j;
    median_t           res;
    if (item.restart == RESTART) begin
      ring_fill = 0;
      ring_ptr  = 0;
    end else begin
      ring_q[ring_ptr] = item.sample;
      ring_ptr = (ring_ptr == WIN - 1) ? 0 : ring_ptr + 1;
      // The fill count saturates at a full window instead of wrapping.
      if (ring_fill < WIN) ring_fill++;
    end
    res.value = '0;
    res.full  = 1'b0;
    if (ring_fill == WIN) begin
      ordered = ring_q;
      for (int i = 1; i < WIN; i++) begin
        key = ordered[i];
        j   = i;
        while (j > 0 && ordered[j-1] > key) begin
          ordered[j] = ordered[j-1];
          j--;
        end
        ordered[j] = key;
      end
      // For an even window this picks the upper of the two middle entries.
      res.value = ordered[WIN/2];
      res.full  = 1'b1;
    end
    return res;
  endfunction

  task automatic send(input logic [DATA_W-1:0] sample, input logic restart);
    samples_to_send.push_back('{sample: sample, restart: restart});
  endtask

  // Random traffic: mostly runs of at least one full window with one content
  // style each, separated by restarts. About one run in eight is cut short
  // before the window fills. A restart carries a random sample that the
  // block must ignore.
  task automatic queue_random_items(input int count);
    int                left;
    int                run_len;
    value_style_e      style;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] v;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 7) == 0) run_len = $urandom_range(0, WIN - 1);
      else run_len = $urandom_range(WIN, 80);
      style = value_style_e'($urandom_range(0, 3));
      base  = DATA_W'($urandom);
      for (int i = 0; i < run_len && left > 0; i++) begin
        case (style)
          NEAR_BASE: v = base + DATA_W'($urandom_range(0, 3));
          RAIL: v = $urandom_range(0, 1) ? {DATA_W{1'b1}} : {DATA_W{1'b0}};
          ONE_HOT: begin
            v = '0;
            v[$urandom_range(0, DATA_W - 1)] = 1'b1;
            if ($urandom_range(0, 1) == 1) v = ~v;
          end
          default: v = DATA_W'($urandom);
        endcase
        send(v, FEED);
        left--;
      end
      if (left > 0) begin
        send(DATA_W'($urandom), RESTART);
        left--;
      end
    end
  endtask

  // Holds the sender back until every offered item has been taken and every
  // expected median has come back.
  task automatic wait_for_drain();
    while (samples_to_send.size() != 0 || s_axis_tvalid || medians_due.size() != 0)
      @(posedge clk);
  endtask

  // Input driver. An offered item is held until taken; after that the
  // sender waits the gap drawn for it before offering the next one. Now and
  // then it switches to a burst mode with no gaps at all.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !in_taken) begin
      // Item still waiting for tready.
    end else if (feed_gap != 0) begin
      s_axis_tvalid <= 1'b0;
      feed_gap = feed_gap - 1;
    end else if (samples_to_send.size() != 0) begin
      next_item = samples_to_send.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= next_item.sample;
      s_axis_tuser  <= next_item.restart;
      if ($urandom_range(0, 63) == 0) feed_burst = !feed_burst;
      feed_gap = feed_burst ? 0 : $urandom_range(0, 11);
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Output receiver. After each result it may stall for a randomly drawn wait,
  // except in burst mode. A long hold asked for by the stimulus keeps tready low
  // for the LONG_HOLD stretch counted here, which backs the block up into its input.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      sink_wait = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait = sink_wait - 1;
      m_axis_tready <= 1'b0;
    end else if (out_taken) begin
      if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
      sink_wait = sink_burst ? 0 : $urandom_range(0, 11);
      if (sink_wait == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        sink_wait = sink_wait - 1;
        m_axis_tready <= 1'b0;
      end
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor. Results are checked before the input of the same edge is
  // predicted, since a result always belongs to an item taken earlier.
  always @(posedge clk) begin
    in_taken  <= !rst && s_axis_tvalid && s_axis_tready;
    out_taken <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst) begin
      cycle_count++;
      if (m_axis_tvalid && m_axis_tready) begin
        if (medians_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, got value %h valid %b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatch_count++;
        end else begin
          due = medians_due.pop_front();
          if (m_axis_tdata !== due.value) begin
            $display("%0t: median_value mismatch: expected %h, got %h",
                     $time, due.value, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tuser !== due.full) begin
            $display("%0t: median_valid mismatch: expected %b, got %b",
                     $time, due.full, m_axis_tuser);
            mismatch_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        medians_due.push_back(next_median('{sample: s_axis_tdata, restart: s_axis_tuser}));
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items unsent and %0d results outstanding",
               $time, samples_to_send.size(), medians_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    ring_ptr  = 0;
    ring_fill = 0;
    foreach (ring_q[i]) ring_q[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill with the extremes and both halves of the range; the median
    // becomes valid on the fifth item.
    send(16'h0000, FEED);
    send(16'hFFFF, FEED);
    send(16'h8000, FEED);
    send(16'h7FFF, FEED);
    send(16'h0001, FEED);
    // Duplicates of the top value push the old entries out one by one.
    send(16'hFFFF, FEED);
    send(16'hFFFF, FEED);
    send(16'hFFFF, FEED);
    send(16'h0000, FEED);
    // Restart from a full window; the sample that comes with it is ignored.
    send(16'hFFFF, RESTART);
    send(16'h1234, FEED);
    // Restart from a partly filled window, then again from an empty one.
    send(16'h0000, RESTART);
    send(16'h5555, RESTART);
    // An all-equal window, then fill saturation with further samples.
    repeat (WIN) send(16'h0000, FEED);
    send(16'hFFFF, FEED);
    send(16'h0010, FEED);
    send(16'h000F, FEED);
    send(16'h000E, FEED);
    send(16'h000D, FEED);
    send(16'h000C, FEED);
    send(16'h0011, FEED);
    wait_for_drain();

    // First random part, with the receiver held off long enough for the
    // block to fill and push back on its input.
    queue_random_items(650);
    holds_asked++;
    wait_for_drain();

    queue_random_items(650);
    queue_random_items(600);
    wait_for_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && medians_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/swm_chain.sv
hdl/sliding_window_median.sv
tb/sliding_window_median_test.sv
